/* sv/source_map_mapping_decoder_defines.svh */
// Assertion macros for the source map mappings decoder.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SOURCE_MAP_MAPPING_DECODER_DEFINES_SVH
`define SOURCE_MAP_MAPPING_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SMAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SMAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/smap_pkg.sv */
// Shared types, codes and helper functions for the mappings decoder.
// No dependencies; imported by smap_step and source_map_mapping_decoder.
package smap_pkg;

    localparam logic [30:0] SAT31 = '1;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_VLQ   = 3'd1;
    localparam logic [2:0] ERR_TRUNC = 3'd2;
    localparam logic [2:0] ERR_NAME  = 3'd3;
    localparam logic [2:0] ERR_NEG   = 3'd4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    localparam logic [5:0] DIG_LOWER_BASE = 6'd26;
    localparam logic [5:0] DIG_NUM_BASE   = 6'd52;
    localparam logic [5:0] DIG_PLUS       = 6'd62;
    localparam logic [5:0] DIG_SLASH      = 6'd63;

    localparam logic [2:0] FP_FIRST = 3'd0;
    localparam logic [2:0] FP_INDEX = 3'd1;
    localparam logic [2:0] FP_LINE  = 3'd2;
    localparam logic [2:0] FP_COL   = 3'd3;
    localparam logic [2:0] FP_NAME  = 3'd4;
    localparam logic [2:0] FP_END   = 3'd5;
    localparam logic [2:0] GC_LIMIT = 3'd7;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } smap_in_t;

    typedef struct packed {
        logic        segment_valid;
        logic        text_done;
        logic [2:0]  error_code;
        logic [30:0] generated_line;
        logic [30:0] source_index;
        logic [30:0] source_line;
    } smap_out_t;

    typedef struct packed {
        logic [30:0] line_counter;
        logic [31:0] running_source;
        logic [31:0] running_source_line;
        logic [31:0] vlq_accumulator;
        logic [2:0]  group_count;
        logic [2:0]  field_position;
        logic        stopped_on_error;
    } smap_state_t;

    localparam smap_state_t STATE_CLEAR = '0;

    // bit 6 set when c is a Base64 digit, bits 5:0 hold its value
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = '0;
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                diff = c - CH_UPPER_A;
                digit_of = {1'b1, diff[5:0]};
            end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                diff = c - CH_LOWER_A;
                digit_of = {1'b1, diff[5:0] + DIG_LOWER_BASE};
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                diff = c - CH_ZERO;
                digit_of = {1'b1, diff[5:0] + DIG_NUM_BASE};
            end else if (c == CH_PLUS) begin
                digit_of = {1'b1, DIG_PLUS};
            end else if (c == CH_SLASH) begin
                digit_of = {1'b1, DIG_SLASH};
            end else begin
                digit_of = {1'b0, diff[5:0]};
            end
        end
    endfunction

    function automatic logic [2:0] field_error(input logic [2:0] fp);
        if (fp == FP_FIRST)
            field_error = ERR_VLQ;
        else if (fp == FP_NAME)
            field_error = ERR_NAME;
        else
            field_error = ERR_TRUNC;
    endfunction

    function automatic logic [30:0] plus_one_sat(input logic [30:0] v);
        plus_one_sat = (v == SAT31) ? v : v + 31'd1;
    endfunction

endpackage

/* sv/smap_step.sv */
// Per-character decode step: next parser state and optional result word.
// Pure combinational; depends on smap_pkg.
module smap_step (
    input  smap_pkg::smap_state_t state,
    input  smap_pkg::smap_in_t    item,
    output smap_pkg::smap_state_t state_next,
    output smap_pkg::smap_out_t   res,
    output logic                  has_res
);
    import smap_pkg::*;

    logic [6:0]  dig;
    logic [5:0]  shamt;
    logic [31:0] grp;
    logic [31:0] acc;
    logic [31:0] mag;
    logic [31:0] val;
    logic [2:0]  gc_inc;
    logic        more;
    logic        is_term;
    logic        neg;
    logic        seg;
    logic        done;
    logic [2:0]  err;
    smap_state_t st;

    always_comb
    begin
        st      = state;
        err     = ERR_NONE;
        seg     = 1'b0;
        done    = 1'b0;
        dig     = digit_of(item.char_code);
        more    = dig[5];
        is_term = (item.char_code == CH_SEMI) || (item.char_code == CH_COMMA);
        // group n sits at bit 5n, wrapped to the 32-bit word
        shamt   = ({3'b000, state.group_count} << 2) + {3'b000, state.group_count};
        grp     = {27'd0, dig[4:0]} << shamt[4:0];
        acc     = state.vlq_accumulator | grp;
        mag     = acc >> 1;
        val     = acc[0] ? (32'd0 - mag) : mag;
        gc_inc  = state.group_count + 3'd1;
        // every emit point sees the running values as they were on entry
        neg     = state.running_source[31] | state.running_source_line[31];

        if (state.stopped_on_error) begin
            if (item.last_char)
                st = STATE_CLEAR;
        end else begin
            if (state.group_count == 3'd0 && is_term &&
                (state.field_position == FP_FIRST || state.field_position == FP_INDEX ||
                 state.field_position == FP_NAME)) begin
                if (state.field_position == FP_NAME) begin
                    if (neg)
                        err = ERR_NEG;
                    else
                        seg = 1'b1;
                end
                st.field_position = FP_FIRST;
                if (err == ERR_NONE && item.char_code == CH_SEMI &&
                    state.line_counter != SAT31)
                    st.line_counter = state.line_counter + 31'd1;
            end else if (!dig[6]) begin
                err = field_error(state.field_position);
            end else begin
                st.vlq_accumulator = acc;
                st.group_count     = gc_inc;
                if (more && gc_inc == GC_LIMIT) begin
                    err = field_error(state.field_position);
                end else if (!more) begin
                    if (state.field_position == FP_INDEX)
                        st.running_source = state.running_source + val;
                    else if (state.field_position == FP_LINE)
                        st.running_source_line = state.running_source_line + val;
                    st.field_position  = state.field_position + 3'd1;
                    st.vlq_accumulator = '0;
                    st.group_count     = '0;
                    if (st.field_position == FP_END) begin
                        if (neg)
                            err = ERR_NEG;
                        else
                            seg = 1'b1;
                        st.field_position = FP_FIRST;
                    end
                end
            end

            if (err == ERR_NONE && item.last_char) begin
                if (st.group_count != 3'd0) begin
                    err = field_error(st.field_position);
                end else if (st.field_position == FP_LINE || st.field_position == FP_COL) begin
                    err = ERR_TRUNC;
                end else if (st.field_position == FP_NAME) begin
                    if (neg)
                        err = ERR_NEG;
                    else
                        seg = 1'b1;
                end
                done = 1'b1;
            end

            if (err != ERR_NONE) begin
                seg = 1'b0;
                done = 1'b1;
                st = STATE_CLEAR;
                st.stopped_on_error = !item.last_char;
            end else if (item.last_char) begin
                st = STATE_CLEAR;
            end
        end

        state_next         = st;
        has_res            = seg | done;
        res.segment_valid  = seg;
        res.text_done      = done;
        res.error_code     = err;
        res.generated_line = seg ? plus_one_sat(state.line_counter) : '0;
        res.source_index   = seg ? state.running_source[30:0] : '0;
        res.source_line    = seg ? plus_one_sat(state.running_source_line[30:0]) : '0;
    end

endmodule

/* sv/source_map_mapping_decoder.sv */
// Source map v3 mappings decoder, one character word in, zero or one result word out.
// Depends on smap_pkg, smap_step and source_map_mapping_decoder_defines.svh.
//
// Channel text carries one mappings byte and a last-character mark per word;
// channel result carries decoded segments, end-of-text and error reports.
// Both use valid/stall: a word moves on a rising edge with valid high and
// stall low.
// A character in the input register is decoded and its result word, if any,
// is loaded into the result register, and shown from then on, once that
// register is not stalled. Throughput: one character per cycle unless stalled;
// the decode is a single combinational step between the two registers.
// Characters that make no result (digits mid-segment, separators, bytes
// skipped after an error) leave the result register untouched.
// When the receiver stalls with a result waiting, the input register holds
// one more character and text_stall rises only once that register is full
// too. The result word holds steady while stalled.
// Reset clears both registers' valid flags, the line counter, the running
// source index and line, and the VLQ accumulator; the block is ready as soon
// as reset is released. Each last-character mark returns the parser to the
// same cleared state for the next text.
module source_map_mapping_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_stall,
    input  smap_pkg::smap_in_t  text,
    output logic                result_valid,
    input  logic                result_stall,
    output smap_pkg::smap_out_t result
);
    import smap_pkg::*;

    `include "source_map_mapping_decoder_defines.svh"

    smap_in_t    in_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    smap_out_t   out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    smap_state_t state_reg;
    smap_state_t state_next;
    smap_out_t   step_res;
    logic        step_has_res;
    logic        out_block;
    logic        fire;
    logic        take;

    smap_step u_step (
        .state      (state_reg),
        .item       (in_reg),
        .state_next (state_next),
        .res        (step_res),
        .has_res    (step_has_res)
    );

    assign out_block  = out_valid_reg && result_stall;
    assign fire       = in_valid_reg && !out_block;
    assign text_stall = in_valid_reg && out_block;
    assign take       = text_valid && !text_stall;

    always_comb
    begin
        in_valid_next = take || (in_valid_reg && !fire);
        if (fire)
            out_valid_next = step_has_res;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= text;
        if (fire && step_has_res)
            out_reg <= step_res;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `SMAP_ASSERT_NOW(a_seg_no_error, result_valid && result.segment_valid, result.error_code == ERR_NONE, "segment word carries an error code")
    `SMAP_ASSERT_NOW(a_error_ends_text, result_valid && result.error_code != ERR_NONE, result.text_done, "error word without text_done")
    `SMAP_ASSERT_NOW(a_silent_after_error, fire && state_reg.stopped_on_error, !step_has_res, "result produced while skipping after an error")
    `SMAP_ASSERT_NEXT(a_stall_holds_input, text_stall, in_valid_reg, "input register lost a word under stall")

endmodule
